// File: design/irpw_pkg.sv
`timescale 1ns / 1ps
// ============================================================================
// irpw_pkg
// Shared types and codes for the infrared pulse width capture block.
// ============================================================================
package irpw_pkg;

   // Input word operation codes
   typedef enum logic [1:0] {
      OP_TICK   = 2'd0,
      OP_RESUME = 2'd1,
      OP_READ   = 2'd2,
      OP_NONE   = 2'd3
   } op_type;

   // Configuration register indexes
   localparam logic [1:0] CSR_GAP_LEN      = 2'd0;
   localparam logic [1:0] CSR_MARK_LEVEL   = 2'd1;
   localparam logic [1:0] CSR_BLINK_ENABLE = 2'd2;

   // Configuration reset values
   localparam logic [15:0] GAP_LEN_RESET = 16'd100;

   // Reported capture state codes
   localparam logic [1:0] CAP_IDLE  = 2'd0;
   localparam logic [1:0] CAP_MARK  = 2'd1;
   localparam logic [1:0] CAP_SPACE = 2'd2;
   localparam logic [1:0] CAP_STOP  = 2'd3;

   // Capture phase, one-hot
   typedef enum logic [3:0] {
      PH_IDLE  = 4'b0001,
      PH_MARK  = 4'b0010,
      PH_SPACE = 4'b0100,
      PH_STOP  = 4'b1000
   } phase_type;

   typedef struct packed {
      logic [15:0] gap_len;
      logic        mark_level;
      logic        blink_enable;
   } cfg_type;

   // Status of one result word (entry value comes from the buffer read port)
   typedef struct packed {
      logic [1:0] capture_state;
      logic       frame_ready;
      logic [7:0] entry_count;
      logic       activity;
      logic       read_hit;
   } rsp_status_type;

   function automatic logic [1:0] phase_code(phase_type ph);
      logic [1:0] code;
      unique case (ph)
         PH_IDLE:  code = CAP_IDLE;
         PH_MARK:  code = CAP_MARK;
         PH_SPACE: code = CAP_SPACE;
         PH_STOP:  code = CAP_STOP;
         default:  code = CAP_IDLE;
      endcase
      return code;
   endfunction

endpackage

// File: design/ir_pulse_width_capture_core.sv
`timescale 1ns / 1ps
// ============================================================================
// ir_pulse_width_capture_core
// Infrared mark/space width capture with gap-qualified frame start.
//
//   port group | direction | handshake          | content
//   req_       | in        | req_valid/req_stall | op, ir_level, read_index
//   rsp_       | out       | rsp_valid/rsp_stall | state, ready, count, value, activity
//   csr_       | in        | csr_valid/csr_ready | index, wdata
//
// One word per cycle while the held result is not stalled; each word gives one result in the cycle after acceptance.
// State, buffer write and buffer read all happen at the accepting edge; the
// result register takes the status at the same edge.
// A new word is taken when no result is held or the held result is taken in the same cycle.
// Reset (synchronous) clears phase, tick count, fill count and indicator and
// loads the configuration defaults; the buffer is not cleared, entries at or
// above the count read as zero.
// ============================================================================
module ir_pulse_width_capture_core #(
   parameter int BUF_ENTRIES = 128,
   parameter int TICK_BITS   = 16
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [1:0]  req_op,
   input  logic        req_ir_level,
   input  logic [6:0]  req_read_index,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [1:0]  rsp_capture_state,
   output logic        rsp_frame_ready,
   output logic [7:0]  rsp_entry_count,
   output logic [15:0] rsp_entry_value,
   output logic        rsp_activity,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [1:0]  csr_index,
   input  logic [15:0] csr_wdata
);
   import irpw_pkg::*;

   localparam int AW = $clog2(BUF_ENTRIES);

   cfg_type        cfg_ff;
   rsp_status_type status, status_q;
   logic           accept;
   logic           wr_en, rd_en;
   logic [AW-1:0]  wr_addr, rd_addr;
   logic [15:0]    wr_data, rd_data;

   assign req_stall = rsp_valid && rsp_stall;
   assign accept    = req_valid && !req_stall;
   assign csr_ready = 1'b1;

   // Configuration registers; writes beyond the list are dropped
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.gap_len      <= GAP_LEN_RESET;
         cfg_ff.mark_level   <= 1'b0;
         cfg_ff.blink_enable <= 1'b0;
      end else if (csr_valid && csr_ready) begin
         unique case (csr_index)
            CSR_GAP_LEN:      cfg_ff.gap_len      <= csr_wdata;
            CSR_MARK_LEVEL:   cfg_ff.mark_level   <= csr_wdata[0];
            CSR_BLINK_ENABLE: cfg_ff.blink_enable <= csr_wdata[0];
            default: begin
            end
         endcase
      end
   end

   irpw_capture #(
      .BUF_ENTRIES (BUF_ENTRIES),
      .TICK_BITS   (TICK_BITS),
      .AW          (AW)
   ) u_capture (
      .clock          (clock),
      .reset          (reset),
      .accept         (accept),
      .req_op         (req_op),
      .req_ir_level   (req_ir_level),
      .req_read_index (req_read_index),
      .cfg            (cfg_ff),
      .status         (status),
      .wr_en          (wr_en),
      .wr_addr        (wr_addr),
      .wr_data        (wr_data),
      .rd_en          (rd_en),
      .rd_addr        (rd_addr)
   );

   irpw_store #(
      .BUF_ENTRIES (BUF_ENTRIES),
      .AW          (AW)
   ) u_store (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   irpw_rsp_reg u_rsp (
      .clock      (clock),
      .reset      (reset),
      .load       (accept),
      .status_in  (status),
      .rsp_stall  (rsp_stall),
      .rsp_valid  (rsp_valid),
      .status_out (status_q)
   );

   // Drive result word; entry value only for an in-range read
   assign rsp_capture_state = status_q.capture_state;
   assign rsp_frame_ready   = status_q.frame_ready;
   assign rsp_entry_count   = status_q.entry_count;
   assign rsp_activity      = status_q.activity;
   assign rsp_entry_value   = status_q.read_hit ? rd_data : 16'd0;

   // Frame ready is only reported in the stopped state
   a_ready_stopped: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_frame_ready |-> rsp_capture_state == CAP_STOP)
      else $error("frame ready outside stopped state");

   // A resume word reports an empty, idle capture
   a_resume_clears: assert property (@(posedge clock) disable iff (reset)
      accept && req_op == OP_RESUME |=>
         rsp_valid && rsp_entry_count == 8'd0 && rsp_capture_state == CAP_IDLE)
      else $error("resume did not clear capture");

   // Only read words carry an entry value
   a_value_read_only: assert property (@(posedge clock) disable iff (reset)
      accept && req_op != OP_READ |=> rsp_entry_value == 16'd0)
      else $error("entry value on a non-read word");
endmodule

// File: design/irpw_store.sv
`timescale 1ns / 1ps
// ============================================================================
// irpw_store
// Width buffer: one write port, one read port with registered read data.
// ============================================================================
module irpw_store #(
   parameter int BUF_ENTRIES = 128,
   parameter int AW          = 7
) (
   input  logic          clock,
   input  logic          wr_en,
   input  logic [AW-1:0] wr_addr,
   input  logic [15:0]   wr_data,
   input  logic          rd_en,
   input  logic [AW-1:0] rd_addr,
   output logic [15:0]   rd_data
);
   logic [15:0] mem [BUF_ENTRIES];
   logic [15:0] rd_data_ff;

   // Write one stored width
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   // Read one entry, hold it until the next read
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;
endmodule

// File: design/irpw_capture.sv
`timescale 1ns / 1ps
// ============================================================================
// irpw_capture
// Capture state: phase, saturating tick counter, fill count and indicator.
// Computes the state after each accepted word and the buffer accesses.
// ============================================================================
module irpw_capture #(
   parameter int BUF_ENTRIES = 128,
   parameter int TICK_BITS   = 16,
   parameter int AW          = 7
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    accept,
   input  logic [1:0]              req_op,
   input  logic                    req_ir_level,
   input  logic [6:0]              req_read_index,
   input  irpw_pkg::cfg_type       cfg,
   output irpw_pkg::rsp_status_type status,
   output logic                    wr_en,
   output logic [AW-1:0]           wr_addr,
   output logic [15:0]             wr_data,
   output logic                    rd_en,
   output logic [AW-1:0]           rd_addr
);
   import irpw_pkg::*;

   localparam int FW = $clog2(BUF_ENTRIES + 1);
   localparam int IW = (AW > 7) ? AW : 7;

   phase_type            phase_ff, phase_in, ph_eff;
   logic [TICK_BITS-1:0] tick_ff, tick_in, tick_inc;
   logic [FW-1:0]        fill_ff, fill_in;
   logic                 ind_ff, ind_in;
   logic                 is_mark, full, do_store, read_hit;
   logic [AW-1:0]        store_addr;
   logic [IW-1:0]        idx_ext;

   assign is_mark  = (req_ir_level == cfg.mark_level);
   assign tick_inc = (&tick_ff) ? tick_ff : tick_ff + TICK_BITS'(1);
   assign full     = 32'(fill_ff) >= 32'(BUF_ENTRIES);
   assign ph_eff   = full ? PH_STOP : phase_ff;
   assign idx_ext  = IW'(req_read_index);
   assign read_hit = (req_op == OP_READ) && (32'(req_read_index) < 32'(fill_ff));

   // Next state for one word
   always_comb begin
      phase_in   = phase_ff;
      tick_in    = tick_ff;
      fill_in    = fill_ff;
      ind_in     = ind_ff;
      do_store   = 1'b0;
      store_addr = fill_ff[AW-1:0];
      unique case (req_op)
         OP_TICK: begin
            phase_in = ph_eff;
            tick_in  = tick_inc;
            unique case (ph_eff)
               PH_IDLE: begin
                  if (is_mark) begin
                     if (32'(tick_inc) < 32'(cfg.gap_len)) begin
                        tick_in = '0;
                     end else begin
                        do_store   = 1'b1;
                        store_addr = '0;
                        phase_in   = PH_MARK;
                     end
                  end
               end
               PH_MARK: begin
                  if (!is_mark) begin
                     do_store = 1'b1;
                     phase_in = PH_SPACE;
                  end
               end
               PH_SPACE: begin
                  if (is_mark) begin
                     do_store = 1'b1;
                     phase_in = PH_MARK;
                  end else if (32'(tick_inc) > 32'(cfg.gap_len)) begin
                     phase_in = PH_STOP;
                  end
               end
               PH_STOP: begin
                  if (is_mark) begin
                     tick_in = '0;
                  end
               end
               default: begin
                  phase_in = PH_IDLE;
               end
            endcase
            if (do_store) begin
               tick_in = '0;
               fill_in = FW'(store_addr) + FW'(1);
            end
            if (cfg.blink_enable) begin
               ind_in = is_mark;
            end
         end
         OP_RESUME: begin
            phase_in = PH_IDLE;
            fill_in  = '0;
         end
         OP_READ: begin
         end
         default: begin
         end
      endcase
   end

   // Advance state on each accepted word
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_IDLE;
         tick_ff  <= '0;
         fill_ff  <= '0;
         ind_ff   <= 1'b0;
      end else if (accept) begin
         phase_ff <= phase_in;
         tick_ff  <= tick_in;
         fill_ff  <= fill_in;
         ind_ff   <= ind_in;
      end
   end

   // Buffer accesses: saturate the stored width to 16 bits
   assign wr_en   = accept && do_store;
   assign wr_addr = store_addr;
   assign wr_data = (32'(tick_inc) > 32'hFFFF) ? 16'hFFFF : 16'(tick_inc);
   assign rd_en   = accept && (req_op == OP_READ);
   assign rd_addr = idx_ext[AW-1:0];

   // Status after the word
   assign status.capture_state = phase_code(phase_in);
   assign status.frame_ready   = (phase_in == PH_STOP) && (fill_in != '0);
   assign status.entry_count   = 8'(fill_in);
   assign status.activity      = ind_in;
   assign status.read_hit      = read_hit;
endmodule

// File: design/irpw_rsp_reg.sv
`timescale 1ns / 1ps
// ============================================================================
// irpw_rsp_reg
// Result register: holds one status word until the consumer takes it.
// ============================================================================
module irpw_rsp_reg (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     load,
   input  irpw_pkg::rsp_status_type status_in,
   input  logic                     rsp_stall,
   output logic                     rsp_valid,
   output irpw_pkg::rsp_status_type status_out
);
   import irpw_pkg::*;

   logic           valid_ff, valid_in;
   rsp_status_type status_ff;

   // Keep a word while stalled, drop it once taken
   assign valid_in = load || (valid_ff && rsp_stall);

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         status_ff <= status_in;
      end
   end

   assign rsp_valid  = valid_ff;
   assign status_out = status_ff;
endmodule
